FILE: src/kdb_pkg.sv
// ----------------------------------------------------------------------------
// kdb_pkg
// Shared types and constants for the knight distance search block: field
// widths, distance codes, knight jump offsets, sequencer states and the
// request and result bundles.
// ----------------------------------------------------------------------------
package kdb_pkg;

  localparam int BOARD_SIDE_DEF = 8;
  localparam int COORD_W        = 3;
  localparam int COUNT_W        = 4;
  localparam int JUMP_N         = 8;
  localparam int JUMP_W         = 3;

  localparam logic [COUNT_W-1:0] UNREACHED = 4'd15;
  localparam logic [COUNT_W-1:0] MAX_DIST  = 4'd14;

  localparam logic signed [2:0] JUMP_DC [JUMP_N] = '{
    3'sd2, 3'sd2, -3'sd2, -3'sd2, 3'sd1, 3'sd1, -3'sd1, -3'sd1
  };
  localparam logic signed [2:0] JUMP_DR [JUMP_N] = '{
    3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd2, -3'sd2, 3'sd2, -3'sd2
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_LOAD,
    ST_BASE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } kdb_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
  } kdb_req_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } kdb_res_t;

endpackage

FILE: src/kdb_jump_gen.sv
// ----------------------------------------------------------------------------
// kdb_jump_gen
// Applies one of the eight knight offsets to a square, flags moves that
// leave the board and forms the cell index of the target square.
// ----------------------------------------------------------------------------
module kdb_jump_gen #(
  parameter int BOARD_SIDE = kdb_pkg::BOARD_SIDE_DEF
) (
  input  logic [$clog2(BOARD_SIDE)-1:0]              cur_col_i,
  input  logic [$clog2(BOARD_SIDE)-1:0]              cur_row_i,
  input  logic [kdb_pkg::JUMP_W-1:0]                 jump_i,
  output logic                                       on_board_o,
  output logic [$clog2(BOARD_SIDE)-1:0]              nxt_col_o,
  output logic [$clog2(BOARD_SIDE)-1:0]              nxt_row_o,
  output logic [$clog2(BOARD_SIDE*BOARD_SIDE)-1:0]   nxt_idx_o
);

  localparam int SideW = $clog2(BOARD_SIDE);
  localparam int CellW = $clog2(BOARD_SIDE * BOARD_SIDE);
  localparam logic signed [SideW+1:0] SideS = (SideW + 2)'(BOARD_SIDE);

  logic signed [SideW+1:0] nc;
  logic signed [SideW+1:0] nr;

  always_comb begin
    nc = $signed({2'b00, cur_col_i}) + (SideW + 2)'(kdb_pkg::JUMP_DC[jump_i]);
    nr = $signed({2'b00, cur_row_i}) + (SideW + 2)'(kdb_pkg::JUMP_DR[jump_i]);
    on_board_o = (nc >= 0) && (nc < SideS) && (nr >= 0) && (nr < SideS);
    nxt_col_o = nc[SideW-1:0];
    nxt_row_o = nr[SideW-1:0];
    nxt_idx_o = CellW'(int'(nr[SideW-1:0]) * BOARD_SIDE + int'(nc[SideW-1:0]));
  end

endmodule

FILE: src/kdb_search_ctrl.sv
// ----------------------------------------------------------------------------
// kdb_search_ctrl
// Breadth-first search sequencer. Holds the distance store (one entry per
// cell, the unreached code doubles as the not-seen mark) and the work queue
// of squares, both as synchronous memories with registered read data.
// ----------------------------------------------------------------------------
module kdb_search_ctrl #(
  parameter int BOARD_SIDE = kdb_pkg::BOARD_SIDE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  kdb_pkg::kdb_req_t req_i,
  output logic              req_ready_o,
  input  logic              out_free_i,
  output kdb_pkg::kdb_res_t res_o
);

  localparam int SideW     = $clog2(BOARD_SIDE);
  localparam int CellCount = BOARD_SIDE * BOARD_SIDE;
  localparam int CellW     = $clog2(CellCount);
  localparam int CntW      = $clog2(CellCount + 1);
  localparam int PosW      = 2 * SideW;
  localparam int CntWc     = kdb_pkg::COUNT_W;

  kdb_pkg::kdb_state_e state_q, state_d;

  logic [CntWc-1:0] dist_mem [CellCount];
  logic [PosW-1:0]  queue_mem [CellCount];

  logic             dist_we;
  logic [CellW-1:0] dist_waddr;
  logic [CntWc-1:0] dist_wdata;
  logic [CellW-1:0] dist_raddr;
  logic [CntWc-1:0] dist_rdata_q;
  logic             queue_we;
  logic [CellW-1:0] queue_waddr;
  logic [PosW-1:0]  queue_wdata;
  logic [CellW-1:0] queue_raddr;
  logic [PosW-1:0]  queue_rdata_q;

  logic [SideW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [SideW-1:0] dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [SideW-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [SideW-1:0] pcol_q, pcol_d, prow_q, prow_d;
  logic [CellW-1:0] pidx_q, pidx_d;
  logic [CellW-1:0] clr_q, clr_d;
  logic [CntW-1:0]  head_q, head_d, tail_q, tail_d;
  logic             found_q, found_d;
  logic             pend_q, pend_d;
  logic [kdb_pkg::JUMP_W-1:0] k_q, k_d;
  logic [CntWc-1:0] nd_q, nd_d;
  logic [CntWc-1:0] res_q, res_d;

  logic [CellW-1:0] src_idx, dst_idx, load_idx;
  logic             jg_on;
  logic [SideW-1:0] jg_col, jg_row;
  logic [CellW-1:0] jg_idx;
  logic             take;
  logic             src_on, dst_on;

  kdb_jump_gen #(
    .BOARD_SIDE(BOARD_SIDE)
  ) u_jump_gen (
    .cur_col_i (cur_col_q),
    .cur_row_i (cur_row_q),
    .jump_i    (k_q),
    .on_board_o(jg_on),
    .nxt_col_o (jg_col),
    .nxt_row_o (jg_row),
    .nxt_idx_o (jg_idx)
  );

  always_comb begin
    src_idx  = CellW'(int'(src_row_q) * BOARD_SIDE + int'(src_col_q));
    dst_idx  = CellW'(int'(dst_row_q) * BOARD_SIDE + int'(dst_col_q));
    load_idx = CellW'(int'(queue_rdata_q[PosW-1:SideW]) * BOARD_SIDE
                      + int'(queue_rdata_q[SideW-1:0]));
    src_on   = (int'(req_i.src_col) < BOARD_SIDE) && (int'(req_i.src_row) < BOARD_SIDE);
    dst_on   = (int'(req_i.dst_col) < BOARD_SIDE) && (int'(req_i.dst_row) < BOARD_SIDE);
    // unseen neighbor waiting from last cycle's read
    take     = pend_q && (dist_rdata_q == kdb_pkg::UNREACHED)
               && (tail_q < CntW'(CellCount));
  end

  always_comb begin
    state_d   = state_q;
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    pcol_d    = pcol_q;
    prow_d    = prow_q;
    pidx_d    = pidx_q;
    clr_d     = clr_q;
    head_d    = head_q;
    tail_d    = tail_q;
    found_d   = found_q;
    pend_d    = pend_q;
    k_d       = k_q;
    nd_d      = nd_q;
    res_d     = res_q;

    dist_we     = 1'b0;
    dist_waddr  = pidx_q;
    dist_wdata  = nd_q;
    dist_raddr  = jg_idx;
    queue_we    = 1'b0;
    queue_waddr = tail_q[CellW-1:0];
    queue_wdata = {prow_q, pcol_q};
    queue_raddr = head_q[CellW-1:0];
    req_ready_o = 1'b0;
    res_o.valid = 1'b0;
    res_o.count = res_q;

    case (state_q)
      kdb_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          src_col_d = SideW'(req_i.src_col);
          src_row_d = SideW'(req_i.src_row);
          dst_col_d = SideW'(req_i.dst_col);
          dst_row_d = SideW'(req_i.dst_row);
          if (src_on && dst_on) begin
            clr_d   = '0;
            state_d = kdb_pkg::ST_CLEAR;
          end else begin
            res_d   = kdb_pkg::UNREACHED;
            state_d = kdb_pkg::ST_DONE;
          end
        end
      end
      kdb_pkg::ST_CLEAR: begin
        dist_we    = 1'b1;
        dist_waddr = clr_q;
        dist_wdata = kdb_pkg::UNREACHED;
        clr_d      = clr_q + 1'b1;
        if (clr_q == CellW'(CellCount - 1)) begin
          state_d = kdb_pkg::ST_SEED;
        end
      end
      kdb_pkg::ST_SEED: begin
        dist_we     = 1'b1;
        dist_waddr  = src_idx;
        dist_wdata  = '0;
        queue_we    = 1'b1;
        queue_waddr = '0;
        queue_wdata = {src_row_q, src_col_q};
        head_d      = '0;
        tail_d      = CntW'(1);
        found_d     = (src_idx == dst_idx);
        res_d       = (src_idx == dst_idx) ? '0 : kdb_pkg::UNREACHED;
        state_d     = kdb_pkg::ST_POP;
      end
      kdb_pkg::ST_POP: begin
        if ((head_q < tail_q) && !found_q) begin
          head_d  = head_q + 1'b1;
          state_d = kdb_pkg::ST_LOAD;
        end else begin
          state_d = kdb_pkg::ST_DONE;
        end
      end
      kdb_pkg::ST_LOAD: begin
        cur_row_d  = queue_rdata_q[PosW-1:SideW];
        cur_col_d  = queue_rdata_q[SideW-1:0];
        dist_raddr = load_idx;
        k_d        = '0;
        state_d    = kdb_pkg::ST_BASE;
      end
      kdb_pkg::ST_BASE: begin
        nd_d    = (dist_rdata_q >= kdb_pkg::MAX_DIST) ? kdb_pkg::MAX_DIST
                                                      : dist_rdata_q + 1'b1;
        pend_d  = jg_on;
        pcol_d  = jg_col;
        prow_d  = jg_row;
        pidx_d  = jg_idx;
        k_d     = k_q + 1'b1;
        state_d = kdb_pkg::ST_SCAN;
      end
      kdb_pkg::ST_SCAN, kdb_pkg::ST_DRAIN: begin
        // neighbors of one square are distinct, so the write never hits the read
        if (take) begin
          dist_we  = 1'b1;
          queue_we = 1'b1;
          tail_d   = tail_q + 1'b1;
          if (pidx_q == dst_idx) begin
            found_d = 1'b1;
            res_d   = nd_q;
          end
        end
        if (state_q == kdb_pkg::ST_SCAN) begin
          pend_d = jg_on;
          pcol_d = jg_col;
          prow_d = jg_row;
          pidx_d = jg_idx;
          k_d    = k_q + 1'b1;
          if (k_q == kdb_pkg::JUMP_W'(kdb_pkg::JUMP_N - 1)) begin
            state_d = kdb_pkg::ST_DRAIN;
          end
        end else begin
          pend_d  = 1'b0;
          state_d = kdb_pkg::ST_POP;
        end
      end
      kdb_pkg::ST_DONE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          state_d     = kdb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kdb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kdb_pkg::ST_IDLE;
      clr_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      found_q <= found_d;
      pend_q  <= pend_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_col_q <= src_col_d;
    src_row_q <= src_row_d;
    dst_col_q <= dst_col_d;
    dst_row_q <= dst_row_d;
    cur_col_q <= cur_col_d;
    cur_row_q <= cur_row_d;
    pcol_q    <= pcol_d;
    prow_q    <= prow_d;
    pidx_q    <= pidx_d;
    nd_q      <= nd_d;
    res_q     <= res_d;
  end

  // distance store
  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rdata_q <= dist_mem[dist_raddr];
  end

  // work queue
  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= queue_wdata;
    end
    queue_rdata_q <= queue_mem[queue_raddr];
  end

endmodule

FILE: src/knight_distance_bfs_unit.sv
// ----------------------------------------------------------------------------
// knight_distance_bfs_unit
// Fewest knight moves between two squares of a square board, found by a
// breadth-first search over a distance store and a work queue in memory.
//
//   channel  direction  handshake                  payload
//   in       request    in_valid_i / in_ready_o    src_col_i src_row_i
//                                                  dst_col_i dst_row_i
//   out      result     out_valid_o / out_ready_i  move_count_o
//
// Each request first clears the distance store, one cell per cycle, then
// seeds the queue with the source square. Every square taken from the
// queue goes through a queue read, a distance read, then the eight jumps
// through the single store read port and a final drain step. A square off
// the board goes straight to the result, with no search.
// Reset is asynchronous and returns the sequencer to idle with no result.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken in.
// ----------------------------------------------------------------------------
module knight_distance_bfs_unit #(
  parameter int BOARD_SIDE = kdb_pkg::BOARD_SIDE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kdb_pkg::COORD_W-1:0] src_col_i,
  input  logic [kdb_pkg::COORD_W-1:0] src_row_i,
  input  logic [kdb_pkg::COORD_W-1:0] dst_col_i,
  input  logic [kdb_pkg::COORD_W-1:0] dst_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kdb_pkg::COUNT_W-1:0] move_count_o
);

  kdb_pkg::kdb_req_t req;
  kdb_pkg::kdb_res_t res;

  logic                        out_valid_q, out_valid_d;
  logic [kdb_pkg::COUNT_W-1:0] count_q, count_d;
  logic                        out_free;

  always_comb begin
    req.src_col = src_col_i;
    req.src_row = src_row_i;
    req.dst_col = dst_col_i;
    req.dst_row = dst_row_i;
    out_free    = !out_valid_q || out_ready_i;
  end

  kdb_search_ctrl #(
    .BOARD_SIDE(BOARD_SIDE)
  ) u_search_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_i      (req),
    .req_ready_o(in_ready_o),
    .out_free_i (out_free),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    count_d     = count_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      count_d     = res.count;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign move_count_o = count_q;

  // a result never overwrites one that has not been taken
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || out_ready_i))
    else $error("result issued into a full output register");

  // an accepted request makes the sequencer busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while sequencer stays idle");

  // a finished search shows up at the output in the next cycle
  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> out_valid_o)
    else $error("finished result not presented");

endmodule

FILE: tb/sv/knight_distance_bfs_unit_tb.sv
// ----------------------------------------------------------------------------
// knight_distance_bfs_unit_tb
// Self-checking bench for the knight distance search block. Square pairs go
// in through the request channel and each move count that comes back is
// compared against an in-bench breadth-first search over the same board.
// Runs directed corner and same-square cases, then random pairs under
// several mixes of sender idling and receiver stalls, plus a long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module knight_distance_bfs_unit_tb;

  localparam int SIDE         = kdb_pkg::BOARD_SIDE_DEF;
  localparam int CELLS        = SIDE * SIDE;
  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_CYCLES  = 2500;
  localparam int TAIL_CYCLES  = 800;
  localparam int LIMIT_CYCLES = 3000000;

  class move_scoreboard;
    logic [kdb_pkg::COUNT_W-1:0] expected_q[$];
    int unsigned                 noted;
    int unsigned                 checked;
    int unsigned                 mismatches;
    bit                          seen[CELLS];
    logic [kdb_pkg::COUNT_W-1:0] reach_dist[CELLS];
    int                          work_q[CELLS];
    int                          jump_col[kdb_pkg::JUMP_N] = '{2, 2, -2, -2, 1, 1, -1, -1};
    int                          jump_row[kdb_pkg::JUMP_N] = '{1, -1, 1, -1, 2, -2, 2, -2};

    function bit on_board(int c, int r);
      return c >= 0 && c < SIDE && r >= 0 && r < SIDE;
    endfunction

    function logic [kdb_pkg::COUNT_W-1:0] knight_moves(kdb_pkg::kdb_req_t r);
      int head, tail, src, dst, cur, cc, cr, nc, nr, nxt, nd;
      head = 0;
      tail = 0;
      for (int i = 0; i < CELLS; i++) begin
        seen[i]       = 1'b0;
        reach_dist[i] = kdb_pkg::UNREACHED;
      end
      if (!on_board(r.src_col, r.src_row) || !on_board(r.dst_col, r.dst_row)) begin
        return kdb_pkg::UNREACHED;
      end
      src = r.src_row * SIDE + r.src_col;
      dst = r.dst_row * SIDE + r.dst_col;
      seen[src]       = 1'b1;
      reach_dist[src] = '0;
      work_q[tail]    = src;
      tail++;
      while (head < tail && reach_dist[dst] == kdb_pkg::UNREACHED) begin
        cur = work_q[head];
        head++;
        cc = cur % SIDE;
        cr = cur / SIDE;
        nd = int'(reach_dist[cur]) + 1;
        if (nd > int'(kdb_pkg::MAX_DIST)) nd = int'(kdb_pkg::MAX_DIST);
        for (int k = 0; k < kdb_pkg::JUMP_N; k++) begin
          nc = cc + jump_col[k];
          nr = cr + jump_row[k];
          if (!on_board(nc, nr)) continue;
          nxt = nr * SIDE + nc;
          if (!seen[nxt] && tail < CELLS) begin
            seen[nxt]       = 1'b1;
            reach_dist[nxt] = nd[kdb_pkg::COUNT_W-1:0];
            work_q[tail]    = nxt;
            tail++;
          end
        end
      end
      return reach_dist[dst];
    endfunction

    function void note_request(kdb_pkg::kdb_req_t r);
      expected_q.insert(expected_q.size(), knight_moves(r));
      noted++;
    endfunction

    function void check_result(logic [kdb_pkg::COUNT_W-1:0] count);
      logic [kdb_pkg::COUNT_W-1:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected move count, expected none, got %0d", $time, count);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (count !== want) begin
        $display("%0t: move_count expected %0d, got %0d", $time, want, count);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_ready_o;
  logic [kdb_pkg::COORD_W-1:0] src_col_i    = '0;
  logic [kdb_pkg::COORD_W-1:0] src_row_i    = '0;
  logic [kdb_pkg::COORD_W-1:0] dst_col_i    = '0;
  logic [kdb_pkg::COORD_W-1:0] dst_row_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i  = 1'b0;
  logic [kdb_pkg::COUNT_W-1:0] move_count_o;

  move_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int same_square    = 0;

  knight_distance_bfs_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_col_i   (src_col_i),
    .src_row_i   (src_row_i),
    .dst_col_i   (dst_col_i),
    .dst_row_i   (dst_row_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .move_count_o(move_count_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver side
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(move_count_o);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout with %0d move counts outstanding", sb.expected_q.size());
    $display("knight_distance_bfs_unit: mismatch");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(kdb_pkg::kdb_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    if (r.src_col == r.dst_col && r.src_row == r.dst_row) same_square++;
    in_valid_i <= 1'b1;
    src_col_i  <= r.src_col;
    src_row_i  <= r.src_row;
    dst_col_i  <= r.dst_col;
    dst_row_i  <= r.dst_row;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
    @(negedge clk_i);
  endtask

  // called at a falling edge
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    kdb_pkg::kdb_req_t r;
    for (int i = 0; i < count; i++) begin
      r.src_col = kdb_pkg::COORD_W'($urandom_range(0, 7));
      r.src_row = kdb_pkg::COORD_W'($urandom_range(0, 7));
      r.dst_col = kdb_pkg::COORD_W'($urandom_range(0, 7));
      r.dst_row = kdb_pkg::COORD_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
        r.dst_col = r.src_col;
        r.dst_row = r.src_row;
      end
      send_request(r);
    end
  endtask

  // octal digits: src col, src row, dst col, dst row
  logic [11:0] directed_reqs[] = '{
    12'o0000, 12'o7777, 12'o0077, 12'o7700, 12'o7007, 12'o0770,
    12'o0011, 12'o7766, 12'o0012, 12'o0021, 12'o3344, 12'o3443,
    12'o0001, 12'o0010, 12'o3333, 12'o0707, 12'o5252, 12'o2525,
    12'o1600, 12'o6177
  };

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_reqs[i]) send_request(kdb_pkg::kdb_req_t'(directed_reqs[i]));
    wait_drained();

    // back-pressure: receiver parked while requests keep coming
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    send_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 61;
    recv_stall_pct = 0;
    send_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 61;
    send_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 37;
    recv_stall_pct = 37;
    send_random(PHASE_ITEMS);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("%0d square pairs sent (%0d directed, %0d same-square), %0d move counts checked",
             sb.noted, directed_reqs.size(), same_square, sb.checked);
    $display("covered idle/stall mixes and a %0d-cycle receiver hold-off", HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("knight_distance_bfs_unit: match");
    end else begin
      $display("knight_distance_bfs_unit: mismatch");
    end
    $finish;
  end

endmodule
